// ===== src/field_weakening_voltage_pi_assert.svh =====
// Assertion macros used by the field weakening voltage PI top level.
`ifndef FIELD_WEAKENING_VOLTAGE_PI_ASSERT_SVH
`define FIELD_WEAKENING_VOLTAGE_PI_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define FWV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("field weakening assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define FWV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("field weakening assertion failed");

`endif

// ===== src/fwv_pkg.sv =====
// Types, constants and tables of the field weakening voltage PI block.
package fwv_pkg;

    typedef struct packed {
        logic               motor_index;
        logic               closed_loop_ready;
        logic signed [15:0] volt_d;
        logic signed [15:0] volt_q;
        logic signed [15:0] d_volt_limit;
        logic signed [15:0] q_volt_limit;
        logic signed [15:0] iq_command;
    } in_word_t;

    typedef struct packed {
        logic               engaged;
        logic signed [15:0] id_reference;
        logic signed [15:0] iq_reference;
        logic [14:0]        current_angle;
        logic [15:0]        volt_magnitude;
        logic [14:0]        volt_reference;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_VD,
        ST_MUL_VQ,
        ST_MUL_REF,
        ST_SQRT,
        ST_ROUND,
        ST_MUL_KI,
        ST_INTEG,
        ST_PI_OUT,
        ST_RANGE,
        ST_CORDIC,
        ST_MUL_C,
        ST_MUL_S,
        ST_FINISH,
        ST_OUT
    } fwv_state_t;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VS_REF_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ID_LIMIT      = 3'd5;

    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 34;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic signed [17:0] HALF_PI_Q13     = 18'sd12868;
    localparam logic signed [28:0] PI_Z            = 29'sd52707179;
    localparam logic signed [28:0] HALF_PI_Z       = 29'sd26353589;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Arctangent of 2^-i in units of 2^-24 rad.
    function automatic logic signed [28:0] atan_lut(input logic [3:0] i);
        logic signed [28:0] v;
        case (i)
            4'd0:    v = 29'sd13176795;
            4'd1:    v = 29'sd7778716;
            4'd2:    v = 29'sd4110060;
            4'd3:    v = 29'sd2086331;
            4'd4:    v = 29'sd1047214;
            4'd5:    v = 29'sd524117;
            4'd6:    v = 29'sd262123;
            4'd7:    v = 29'sd131069;
            4'd8:    v = 29'sd65536;
            4'd9:    v = 29'sd32768;
            4'd10:   v = 29'sd16384;
            4'd11:   v = 29'sd8192;
            4'd12:   v = 29'sd4096;
            4'd13:   v = 29'sd2048;
            4'd14:   v = 29'sd1024;
            default: v = 29'sd512;
        endcase
        return v;
    endfunction

endpackage

// ===== src/fwv_mul.sv =====
// Shared signed multiplier with a registered product.
module fwv_mul (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [fwv_pkg::MUL_A_W-1:0] a,
    input  logic signed [fwv_pkg::MUL_B_W-1:0] b,
    output logic signed [fwv_pkg::MUL_P_W-1:0] prod
);
    import fwv_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== src/field_weakening_voltage_pi.sv =====
// Top level of the voltage feedback field weakening PI regulator.
// Field weakening regulator for up to NUM_MOTORS motors: each input word is one control
// period of one motor and yields exactly one output word. An engaged period runs three
// products on the shared multiplier, a sixteen-step bit-pair square root, the PI update,
// angle range reduction, sixteen CORDIC rotations and two more products. A period that
// is passed through goes straight to the result word. The input is not ready until the
// result word has been taken.
module field_weakening_voltage_pi #(
    parameter int NUM_MOTORS = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  fwv_pkg::in_word_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output fwv_pkg::out_word_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fwv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                         cfg_data
);
    import fwv_pkg::*;
    `include "field_weakening_voltage_pi_assert.svh"

    // Configuration registers.
    logic [1:0]         enable_mask_reg;
    logic [15:0]        prop_gain_reg;
    logic [15:0]        integral_gain_reg;
    logic [15:0]        vs_ref_scale_reg;
    logic signed [15:0] angle_limit_reg;
    logic [14:0]        id_limit_reg;

    fwv_state_t         state_reg, state_next;
    logic [3:0]         cnt_reg, cnt_next;
    in_word_t           in_reg, in_next;
    logic [16:0]        lim_reg, lim_next;
    logic [16:0]        mag_reg, mag_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        root_reg, root_next;
    logic [15:0]        vs_reg, vs_next;
    logic [14:0]        vref_reg, vref_next;
    logic signed [15:0] ui_reg, ui_next;
    logic signed [17:0] angle_reg, angle_next;
    logic signed [28:0] z_reg, z_next;
    logic               flip_reg, flip_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [15:0] id_reg, id_next;
    out_word_t          out_reg, out_next;
    logic signed [15:0] integ_reg [NUM_MOTORS];
    logic signed [15:0] integ_next [NUM_MOTORS];

    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    fwv_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    function automatic logic [16:0] abs17(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return (e < 0) ? 17'(-e) : 17'(e);
    endfunction

    // Clamp into [angle_limit, 0], the upper bound tested first.
    function automatic logic signed [15:0] clamp_angle(input logic signed [23:0] v,
                                                       input logic signed [15:0] al);
        logic signed [15:0] r;
        if (v > 24'sd0)
            r = 16'sd0;
        else if (v < 24'(al))
            r = al;
        else
            r = v[15:0];
        return r;
    endfunction

    logic signed [17:0] err_w;
    logic signed [15:0] integ_cur_w;
    logic               idx_ok_w;
    logic [31:0]        bit_w;
    logic [31:0]        trial_w;
    logic signed [33:0] c_w;
    logic signed [33:0] s_w;
    logic signed [MUL_P_W-1:0] rnd14_w;
    logic signed [MUL_P_W-1:0] rnd30_w;
    logic [31:0]        vref_sum_w;

    assign err_w    = $signed({3'b000, vref_reg}) - $signed({2'b00, vs_reg});
    assign bit_w    = 32'h4000_0000 >> {cnt_reg, 1'b0};
    assign trial_w  = root_reg + bit_w;
    assign c_w      = flip_reg ? -x_reg : x_reg;
    assign s_w      = flip_reg ? -y_reg : y_reg;
    assign rnd14_w  = (prod + MUL_P_W'(8192)) >>> 14;
    assign rnd30_w  = (prod + MUL_P_W'(32'h2000_0000)) >>> 30;
    assign vref_sum_w = prod[31:0] + 32'd16384;

    always_comb
    begin
        idx_ok_w    = 1'b0;
        integ_cur_w = 16'sd0;
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            if (int'(in_reg.motor_index) == m)
            begin
                idx_ok_w    = 1'b1;
                integ_cur_w = integ_reg[m];
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_mask_reg   <= 2'd0;
            prop_gain_reg     <= 16'd0;
            integral_gain_reg <= 16'd0;
            vs_ref_scale_reg  <= 16'd31130;
            angle_limit_reg   <= -16'sd8579;
            id_limit_reg      <= 15'd16384;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ENABLE_MASK:   enable_mask_reg   <= cfg_data[1:0];
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                REG_INTEGRAL_GAIN: integral_gain_reg <= cfg_data;
                REG_VS_REF_SCALE:  vs_ref_scale_reg  <= cfg_data;
                REG_ANGLE_LIMIT:   angle_limit_reg   <= $signed(cfg_data);
                REG_ID_LIMIT:      id_limit_reg      <= cfg_data[14:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 4'd0;
            for (int m = 0; m < NUM_MOTORS; m++)
            begin
                integ_reg[m] <= 16'sd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            for (int m = 0; m < NUM_MOTORS; m++)
            begin
                integ_reg[m] <= integ_next[m];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg    <= in_next;
        lim_reg   <= lim_next;
        mag_reg   <= mag_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        vs_reg    <= vs_next;
        vref_reg  <= vref_next;
        ui_reg    <= ui_next;
        angle_reg <= angle_next;
        z_reg     <= z_next;
        flip_reg  <= flip_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        id_reg    <= id_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        logic signed [23:0] sum;
        logic signed [15:0] pi_out;
        logic signed [21:0] prod22;
        logic signed [16:0] iqr;
        logic signed [33:0] shx;
        logic signed [33:0] shy;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_next    = in_reg;
        lim_next   = lim_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        vs_next    = vs_reg;
        vref_next  = vref_reg;
        ui_next    = ui_reg;
        angle_next = angle_reg;
        z_next     = z_reg;
        flip_next  = flip_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        id_next    = id_reg;
        out_next   = out_reg;
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            integ_next[m] = integ_reg[m];
        end
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        sum    = '0;
        pi_out = '0;
        prod22 = '0;
        iqr    = '0;
        shx    = x_reg >>> cnt_reg;
        shy    = y_reg >>> cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_next  = in_data;
                    lim_next = (abs17(in_data.q_volt_limit) < abs17(in_data.d_volt_limit)) ?
                               abs17(in_data.q_volt_limit) : abs17(in_data.d_volt_limit);
                    mag_next = abs17(in_data.iq_command);
                    if (!enable_mask_reg[in_data.motor_index] || !in_data.closed_loop_ready ||
                        int'(in_data.motor_index) >= NUM_MOTORS)
                    begin
                        for (int m = 0; m < NUM_MOTORS; m++)
                        begin
                            if (int'(in_data.motor_index) == m)
                                integ_next[m] = 16'sd0;
                        end
                        out_next.engaged        = 1'b0;
                        out_next.id_reference   = 16'sd0;
                        out_next.iq_reference   = in_data.iq_command;
                        out_next.current_angle  = 15'(HALF_PI_Q13);
                        out_next.volt_magnitude = 16'd0;
                        out_next.volt_reference = 15'd0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_MUL_VD;
                    end
                end
            end
            ST_MUL_VD:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(in_reg.volt_d);
                mul_b  = MUL_B_W'(in_reg.volt_d);
                state_next = ST_MUL_VQ;
            end
            ST_MUL_VQ:
            begin
                mul_en   = 1'b1;
                mul_a    = MUL_A_W'(in_reg.volt_q);
                mul_b    = MUL_B_W'(in_reg.volt_q);
                rem_next = prod[31:0];
                state_next = ST_MUL_REF;
            end
            ST_MUL_REF:
            begin
                mul_en    = 1'b1;
                mul_a     = $signed({1'b0, lim_reg});
                mul_b     = $signed({18'd0, vs_ref_scale_reg});
                rem_next  = rem_reg + prod[31:0];
                root_next = 32'd0;
                cnt_next  = 4'd0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                // The product of scale and limit stays in the multiplier meanwhile.
                vref_next = (vref_sum_w[31:15] > 17'd32767) ? 15'd32767 : vref_sum_w[29:15];
                if (rem_reg >= trial_w)
                begin
                    rem_next  = rem_reg - trial_w;
                    root_next = (root_reg >> 1) + bit_w;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                // What is left after the last step is x - r*r.
                vs_next = root_reg[15:0] + ((rem_reg > root_reg) ? 16'd1 : 16'd0);
                state_next = ST_MUL_KI;
            end
            ST_MUL_KI:
            begin
                mul_en = 1'b1;
                mul_a  = err_w;
                mul_b  = $signed({18'd0, integral_gain_reg});
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                mul_en  = 1'b1;
                mul_a   = err_w;
                mul_b   = $signed({18'd0, prop_gain_reg});
                sum     = 24'(integ_cur_w) + rnd14_w[23:0];
                ui_next = clamp_angle(sum, angle_limit_reg);
                state_next = ST_PI_OUT;
            end
            ST_PI_OUT:
            begin
                sum    = rnd14_w[23:0] + 24'(ui_reg);
                pi_out = clamp_angle(sum, angle_limit_reg);
                angle_next = HALF_PI_Q13 - 18'(pi_out);
                z_next     = {HALF_PI_Q13 - 18'(pi_out), 11'd0};
                flip_next  = 1'b0;
                for (int m = 0; m < NUM_MOTORS; m++)
                begin
                    if (int'(in_reg.motor_index) == m)
                        integ_next[m] = ui_reg;
                end
                state_next = ST_RANGE;
            end
            ST_RANGE:
            begin
                if (z_reg > HALF_PI_Z)
                begin
                    z_next    = z_reg - PI_Z;
                    flip_next = ~flip_reg;
                end
                else if (z_reg < -HALF_PI_Z)
                begin
                    z_next    = z_reg + PI_Z;
                    flip_next = ~flip_reg;
                end
                else
                begin
                    x_next   = CORDIC_GAIN_Q30;
                    y_next   = 34'sd0;
                    cnt_next = 4'd0;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - shy;
                    y_next = y_reg + shx;
                    z_next = z_reg - atan_lut(cnt_reg);
                end
                else
                begin
                    x_next = x_reg + shy;
                    y_next = y_reg - shx;
                    z_next = z_reg + atan_lut(cnt_reg);
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({1'b0, mag_reg});
                mul_b  = c_w;
                state_next = ST_MUL_S;
            end
            ST_MUL_S:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({1'b0, mag_reg});
                mul_b  = s_w;
                prod22 = rnd30_w[21:0];
                if (prod22 < -$signed({7'd0, id_limit_reg}))
                    id_next = -$signed({1'b0, id_limit_reg});
                else if (prod22 > 22'sd0)
                    id_next = 16'sd0;
                else
                    id_next = prod22[15:0];
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                prod22 = in_reg.iq_command[15] ? -rnd30_w[21:0] : rnd30_w[21:0];
                if (prod22 > 22'sd32767)
                    iqr = 17'sd32767;
                else if (prod22 < -22'sd32768)
                    iqr = -17'sd32768;
                else
                    iqr = prod22[16:0];
                out_next.engaged        = 1'b1;
                out_next.id_reference   = id_reg;
                out_next.iq_reference   = iqr[15:0];
                if (angle_reg < 0)
                    out_next.current_angle = 15'd0;
                else if (angle_reg > 18'sd32767)
                    out_next.current_angle = 15'd32767;
                else
                    out_next.current_angle = angle_reg[14:0];
                out_next.volt_magnitude = vs_reg;
                out_next.volt_reference = vref_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A result word and a new input word never overlap.
    `FWV_ASSERT_NOW(a_ready_excl_valid, in_ready, !out_valid)
    // Each accepted word starts work that holds the input closed.
    `FWV_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
    // Passed-through words carry no d current and the quarter-turn angle.
    `FWV_ASSERT_NOW(a_pass_fields, out_valid && !out_data.engaged,
                    out_data.id_reference == 16'sd0 &&
                    out_data.current_angle == 15'(HALF_PI_Q13) &&
                    out_data.volt_magnitude == 16'd0)
    // The CORDIC starts only on a reduced angle.
    `FWV_ASSERT_NEXT(a_cordic_range, state_reg == ST_RANGE && state_next == ST_CORDIC,
                     z_reg <= HALF_PI_Z && z_reg >= -HALF_PI_Z)
    // Integrator updates happen only on a legal motor index.
    `FWV_ASSERT_NOW(a_integ_index, state_reg == ST_PI_OUT, idx_ok_w)

endmodule
